// ===== rtl/mcma_pkg.sv =====
// shared constants and register codes for the multichannel moving average block
package mcma_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CHANNEL_W    = 4;
    localparam int CFG_W        = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int FLEN_W       = 6;
    localparam int USE_W        = 5;
    localparam int MAXCH_W      = 4;
    localparam int ACTIVE_W     = 6;
    localparam int ACTIVE_MAX   = 63;
    localparam int DEF_CHANNELS = 16;
    localparam int DEF_WINDOW   = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_LENGTH   = 2'd0,
        CFG_CHANNELS_IN_USE = 2'd1,
        CFG_MAX_CHANNEL     = 2'd2,
        CFG_SKIP_ZERO       = 2'd3
    } cfg_reg_t;

endpackage

// ===== rtl/multichannel_moving_average_max.sv =====
// multichannel moving average filter with running maxima of raw and filtered values
//
// usage: one request on the input channel carries one channel's sample of a record,
// record_end marks the record's last channel. every request yields one result with
// the channel, the window mean (or the raw sample) and both running maxima.
// configuration is written through cfg_write/cfg_index/cfg_data; the user must write it
// only while idle, the block itself does not enforce this. one request is handled at a
// time. a sample that passes raw goes through the finish state into the output register;
// a filtered sample first walks the history memory (one read per cycle over the window in
// use, then the last read data and a decision), then runs through the shared divider and
// the finish state into the output register. the next request is taken once the result
// is loaded into the output register.
// with skip_zero set and no positive sample the divider is bypassed.
// the history is a synchronous memory of CHANNELS*WINDOW samples; entries hold
// whatever was last written, there is no clearing pass after reset.
// reset clears state, configuration, maxima and counters; max_channel resets to CHANNELS-1.
// a result waits in the output register while out_ready is low; the next request
// is still taken and worked on, and its result waits until the register is free.
module multichannel_moving_average_max #(
    parameter int CHANNELS = mcma_pkg::DEF_CHANNELS,
    parameter int WINDOW   = mcma_pkg::DEF_WINDOW
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mcma_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcma_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mcma_pkg::CHANNEL_W-1:0]      channel,
    input  logic signed [mcma_pkg::SAMPLE_W-1:0] sample,
    input  logic                                active,
    input  logic                                record_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mcma_pkg::CHANNEL_W-1:0]      out_channel,
    output logic signed [mcma_pkg::SAMPLE_W-1:0] filtered,
    output logic signed [mcma_pkg::SAMPLE_W-1:0] max_filtered,
    output logic signed [mcma_pkg::SAMPLE_W-1:0] max_raw
);

    localparam int SW     = mcma_pkg::SAMPLE_W;
    localparam int CW     = mcma_pkg::CHANNEL_W;
    localparam int NMAX   = (WINDOW < mcma_pkg::ACTIVE_MAX) ? WINDOW : mcma_pkg::ACTIVE_MAX;
    localparam int CNT_W  = $clog2(NMAX + 1);
    localparam int SUM_W  = SW + $clog2(NMAX);
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AW     = mcma_pkg::ACTIVE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [mcma_pkg::FLEN_W-1:0]     filter_length_reg;
    logic [mcma_pkg::USE_W-1:0]      channels_in_use_reg;
    logic [mcma_pkg::MAXCH_W-1:0]    max_channel_reg;
    logic                            skip_zero_reg;
    logic [PTR_W-1:0]                ptr_reg;
    logic [AW-1:0]                   active_reg;
    logic signed [SW-1:0]            peak_f_reg;
    logic signed [SW-1:0]            peak_r_reg;

    logic [CW-1:0]                   ch_reg;
    logic signed [SW-1:0]            sample_reg;
    logic [CNT_W-1:0]                n_reg;
    logic [PTR_W-1:0]                slot_reg;
    logic [CNT_W-1:0]                issue_cnt_reg;
    logic                            rd_pend_reg;
    logic signed [SUM_W-1:0]         wsum_reg;
    logic [SUM_W-1:0]                psum_reg;
    logic [CNT_W-1:0]                pcnt_reg;
    logic signed [SW-1:0]            res_reg;
    logic                            div_start_reg;

    logic                            out_valid_reg;
    logic [CW-1:0]                   out_channel_reg;
    logic signed [SW-1:0]            filtered_reg;
    logic signed [SW-1:0]            max_filtered_reg;
    logic signed [SW-1:0]            max_raw_reg;

    logic                            accept;
    logic                            ch_ok_in;
    logic                            filt_in;
    logic [mcma_pkg::FLEN_W-1:0]     fl_eff;
    logic [AW:0]                     run_len;
    logic [AW:0]                     n_wide;
    logic [CNT_W-1:0]                n_in;
    logic [PTR_W-1:0]                ptr_next;
    logic [PTR_W-1:0]                slot_next;
    logic [PTR_W-1:0]                base_slot;
    logic [CW-1:0]                   base_ch;
    logic                            ring_we;
    logic [ADDR_W-1:0]               ring_addr;
    logic [SW-1:0]                   ring_rdata;
    logic signed [SW-1:0]            rd_val;
    logic                            issue_done;
    logic                            neg;
    logic [SUM_W-1:0]                div_dividend;
    logic [CNT_W-1:0]                div_divisor;
    logic                            div_done;
    logic [SUM_W-1:0]                div_quotient;
    logic [SUM_W-1:0]                signed_q;
    logic                            ch_ok_reg;
    logic                            upd_peak;
    logic                            fire;
    logic signed [SW-1:0]            peak_f_next;
    logic signed [SW-1:0]            peak_r_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign ch_ok_in = int'(channel) < CHANNELS;

    always_comb
    begin
        fl_eff  = (int'(filter_length_reg) > WINDOW) ? mcma_pkg::FLEN_W'(WINDOW)
                                                     : filter_length_reg;
        filt_in = (filter_length_reg != '0) && active && ch_ok_in
                  && (int'(channel) < int'(channels_in_use_reg));
        run_len = {1'b0, active_reg} + 1'b1;
        n_wide  = run_len;
        if (int'(n_wide) > mcma_pkg::ACTIVE_MAX)
        begin
            n_wide = (AW + 1)'(mcma_pkg::ACTIVE_MAX);
        end
        if (n_wide > {1'b0, fl_eff})
        begin
            n_wide = {1'b0, fl_eff};
        end
        n_in = CNT_W'(n_wide);
    end

    assign ptr_next  = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    assign slot_next = (slot_reg == '0) ? PTR_W'(WINDOW - 1) : slot_reg - 1'b1;

    // the idle cycle writes the new sample, later cycles walk back through the window
    assign base_slot = (state_reg == ST_IDLE) ? ptr_reg : slot_reg;
    assign base_ch   = (state_reg == ST_IDLE) ? channel : ch_reg;
    assign ring_we   = accept && ch_ok_in;
    assign ring_addr = ADDR_W'(ADDR_W'(base_slot) * ADDR_W'(CHANNELS)) + ADDR_W'(base_ch);

    mcma_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .addr  (ring_addr),
        .wdata (sample),
        .rdata (ring_rdata)
    );

    assign rd_val     = ring_rdata;
    assign issue_done = (issue_cnt_reg == n_reg);
    assign neg        = !skip_zero_reg && wsum_reg[SUM_W-1];

    always_comb
    begin
        if (skip_zero_reg)
        begin
            div_dividend = psum_reg;
            div_divisor  = pcnt_reg;
        end
        else
        begin
            div_dividend = neg ? SUM_W'(-wsum_reg) : SUM_W'(wsum_reg);
            div_divisor  = n_reg;
        end
    end

    mcma_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign signed_q = neg ? (~div_quotient + 1'b1) : div_quotient;

    always_comb
    begin
        ch_ok_reg   = int'(ch_reg) < CHANNELS;
        upd_peak    = ch_ok_reg && (ch_reg <= max_channel_reg);
        fire        = !out_valid_reg || out_ready;
        peak_f_next = (upd_peak && (res_reg > peak_f_reg)) ? res_reg : peak_f_reg;
        peak_r_next = (upd_peak && (sample_reg > peak_r_reg)) ? sample_reg : peak_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            filter_length_reg   <= '0;
            channels_in_use_reg <= '0;
            max_channel_reg     <= mcma_pkg::MAXCH_W'(CHANNELS - 1);
            skip_zero_reg       <= 1'b0;
            ptr_reg             <= '0;
            active_reg          <= '0;
            peak_f_reg          <= '0;
            peak_r_reg          <= '0;
            issue_cnt_reg       <= '0;
            rd_pend_reg         <= 1'b0;
            div_start_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg        <= channel;
                        sample_reg    <= sample;
                        res_reg       <= sample;
                        n_reg         <= n_in;
                        slot_reg      <= ptr_reg;
                        issue_cnt_reg <= '0;
                        rd_pend_reg   <= 1'b0;
                        wsum_reg      <= '0;
                        psum_reg      <= '0;
                        pcnt_reg      <= '0;
                        if (record_end)
                        begin
                            ptr_reg <= ptr_next;
                            if (filter_length_reg != '0)
                            begin
                                if (!active)
                                begin
                                    active_reg <= '0;
                                end
                                else if (int'(active_reg) < mcma_pkg::ACTIVE_MAX)
                                begin
                                    active_reg <= active_reg + 1'b1;
                                end
                            end
                        end
                        state_reg <= filt_in ? ST_READ : ST_FINISH;
                    end
                end

                ST_READ:
                begin
                    // read data is registered and arrives in the cycle after its address
                    if (rd_pend_reg)
                    begin
                        wsum_reg <= wsum_reg + {{(SUM_W - SW){rd_val[SW-1]}}, rd_val};
                        if (rd_val > 0)
                        begin
                            psum_reg <= psum_reg + {{(SUM_W - SW){1'b0}}, rd_val};
                            pcnt_reg <= pcnt_reg + 1'b1;
                        end
                    end
                    if (!issue_done)
                    begin
                        slot_reg      <= slot_next;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        rd_pend_reg   <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg)
                        begin
                            if (skip_zero_reg && (pcnt_reg == '0))
                            begin
                                res_reg   <= '0;
                                state_reg <= ST_FINISH;
                            end
                            else
                            begin
                                div_start_reg <= 1'b1;
                                state_reg     <= ST_DIV;
                            end
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= signed_q[SW-1:0];
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (fire)
                    begin
                        peak_f_reg       <= peak_f_next;
                        peak_r_reg       <= peak_r_next;
                        out_valid_reg    <= 1'b1;
                        out_channel_reg  <= ch_reg;
                        filtered_reg     <= res_reg;
                        max_filtered_reg <= peak_f_next;
                        max_raw_reg      <= peak_r_next;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_write)
            begin
                case (cfg_index)
                    mcma_pkg::CFG_FILTER_LENGTH:
                    begin
                        filter_length_reg <= cfg_data[mcma_pkg::FLEN_W-1:0];
                    end
                    mcma_pkg::CFG_CHANNELS_IN_USE:
                    begin
                        channels_in_use_reg <= cfg_data[mcma_pkg::USE_W-1:0];
                    end
                    mcma_pkg::CFG_MAX_CHANNEL:
                    begin
                        // out-of-range channel limits are dropped
                        if (int'(cfg_data[mcma_pkg::MAXCH_W-1:0]) <= CHANNELS - 1)
                        begin
                            max_channel_reg <= cfg_data[mcma_pkg::MAXCH_W-1:0];
                            peak_f_reg      <= '0;
                            peak_r_reg      <= '0;
                        end
                    end
                    mcma_pkg::CFG_SKIP_ZERO:
                    begin
                        skip_zero_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign filtered     = filtered_reg;
    assign max_filtered = max_filtered_reg;
    assign max_raw      = max_raw_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (issue_cnt_reg <= n_reg) && (pcnt_reg <= issue_cnt_reg))
        else $error("history walk ran past the window");

    a_raw_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ch_ok_in) |=> (state_reg == ST_FINISH))
        else $error("unstored channel entered the averaging path");

    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && fire) |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result not loaded into the output register");

endmodule

// ===== rtl/mcma_ring.sv =====
// sample history memory, one write or read port, registered read data
module mcma_ring #(
    parameter int DEPTH  = mcma_pkg::DEF_CHANNELS * mcma_pkg::DEF_WINDOW,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = mcma_pkg::SAMPLE_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcma_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
module mcma_div #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;
    logic [DVS_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
